// ===== rtl/tew_pkg.sv =====
// Shared constants and types for the thermal e-stop watchdog.
`timescale 1ns / 1ps

package tew_pkg;

    // Command codes carried in the slave-side tuser.
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ESTOP_LEVEL    = 2'd0;
    localparam logic [1:0] REG_WARN_LEVEL     = 2'd1;
    localparam logic [1:0] REG_CLEAR_LEVEL    = 2'd2;
    localparam logic [1:0] REG_COOLDOWN_TICKS = 2'd3;

    localparam int TEMP_W  = 16;
    localparam int LEVEL_W = 15;
    localparam int PORT_LANES = 8;

    localparam logic [LEVEL_W-1:0] ESTOP_LEVEL_RST = 15'd1200;
    localparam logic [LEVEL_W-1:0] WARN_LEVEL_RST  = 15'd1040;
    localparam logic [LEVEL_W-1:0] CLEAR_LEVEL_RST = 15'd960;
    localparam logic [31:0]        COOLDOWN_RST    = 32'd30000;

    // One channel as seen by the maximum search: only positive values count.
    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] val;
    } cand_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] estop;
        logic [LEVEL_W-1:0] warn;
        logic [LEVEL_W-1:0] clear;
    } levels_t;

    typedef struct packed {
        logic               estop;
        logic               warning;
        logic               cooling;
        logic               reset_ok;
        logic [LEVEL_W-1:0] max_temp;
    } status_t;

endpackage

// ===== rtl/tew_lane.sv =====
// One channel of temperature storage with its write decode and candidate output.
`timescale 1ns / 1ps

module tew_lane #(
    parameter int CH          = 0,
    parameter int GROUP_LANES = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           upd_en,
    input  logic                           group_sel,
    input  logic [3:0]                     lane_count,
    input  logic [tew_pkg::TEMP_W-1:0]     wdata,
    output tew_pkg::cand_t                 cand
);

    localparam int GRP  = CH / GROUP_LANES;
    localparam int LANE = CH % GROUP_LANES;

    logic [tew_pkg::TEMP_W-1:0] temp_reg;
    logic [tew_pkg::TEMP_W-1:0] temp_next;
    logic                       wr;

    // Lane counts above the group size clamp to it, so a plain compare covers both.
    assign wr = upd_en && (32'(group_sel) == GRP) && (32'(lane_count) > LANE);
    assign temp_next = wr ? wdata : temp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg <= '0;
        end else begin
            temp_reg <= temp_next;
        end
    end

    // The search sees the value as it stands after this transaction's write.
    assign cand.valid = !temp_next[tew_pkg::TEMP_W-1] && (temp_next != '0);
    assign cand.val   = temp_next[tew_pkg::LEVEL_W-1:0];

endmodule

// ===== rtl/tew_max.sv =====
// Merging tree that picks the hottest positive channel, lowest index on ties, registered.
`timescale 1ns / 1ps

module tew_max #(
    parameter int CHANNELS = 16,
    parameter int IDX_W    = 5
) (
    input  logic                        aclk,
    input  logic                        load,
    input  tew_pkg::cand_t              cands [CHANNELS],
    output logic [tew_pkg::LEVEL_W-1:0] best_val_reg,
    output logic [IDX_W-1:0]            best_idx_reg
);

    localparam int P = 2 ** $clog2(CHANNELS);

    typedef struct packed {
        logic                        valid;
        logic [tew_pkg::LEVEL_W-1:0] val;
        logic [IDX_W-1:0]            idx;
    } node_t;

    node_t                        node [1:2*P-1];
    logic [tew_pkg::LEVEL_W-1:0]  best_val_next;
    logic [IDX_W-1:0]             best_idx_next;

    always_comb begin
        for (int i = 0; i < P; i++) begin
            if (i < CHANNELS) begin
                node[P+i].valid = cands[i].valid;
                node[P+i].val   = cands[i].val;
            end else begin
                node[P+i].valid = 1'b0;
                node[P+i].val   = '0;
            end
            node[P+i].idx = IDX_W'(i);
        end
        // Left child holds the lower channels, so it wins unless the right is strictly hotter.
        for (int k = P - 1; k >= 1; k--) begin
            if (node[2*k+1].valid && (!node[2*k].valid || node[2*k+1].val > node[2*k].val)) begin
                node[k] = node[2*k+1];
            end else begin
                node[k] = node[2*k];
            end
        end
        if (node[1].valid) begin
            best_val_next = node[1].val;
            best_idx_next = node[1].idx;
        end else begin
            best_val_next = '0;
            best_idx_next = IDX_W'(CHANNELS);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            best_val_reg <= best_val_next;
            best_idx_reg <= best_idx_next;
        end
    end

endmodule

// ===== rtl/tew_latch.sv =====
// E-stop, warning and cooldown latches, updated once per transaction in order.
`timescale 1ns / 1ps

module tew_latch #(
    parameter int CHANNELS    = 16,
    parameter int IDX_W       = 5,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  logic [1:0]                  cmd,
    input  logic [tew_pkg::LEVEL_W-1:0] best_val,
    input  logic [IDX_W-1:0]            best_idx,
    input  tew_pkg::levels_t            levels,
    input  logic [COUNT_WIDTH-1:0]      ticks,
    output tew_pkg::status_t            status,
    output logic [IDX_W-1:0]            hot_idx
);

    logic                        estop_reg, estop_next;
    logic                        warning_reg, warning_next;
    logic                        cooling_reg, cooling_next;
    logic                        ok_reg, ok_next;
    logic [COUNT_WIDTH-1:0]      count_reg, count_next;
    logic [tew_pkg::LEVEL_W-1:0] last_max_reg, last_max_next;
    logic [IDX_W-1:0]            last_hot_reg, last_hot_next;
    logic                        estop_cond, warn_cond, below;

    assign estop_cond = best_val >= levels.estop;
    assign warn_cond  = !estop_cond && (best_val >= levels.warn);
    assign below      = best_val < levels.clear;

    always_comb begin
        estop_next    = estop_reg;
        warning_next  = warning_reg;
        cooling_next  = cooling_reg;
        count_next    = count_reg;
        last_max_next = last_max_reg;
        last_hot_next = last_hot_reg;
        ok_next       = 1'b0;
        unique case (cmd)
            tew_pkg::CMD_UPDATE: begin
                if (estop_cond && !estop_reg) begin
                    estop_next   = 1'b1;
                    cooling_next = 1'b0;
                    count_next   = '0;
                end
                if (estop_next) begin
                    if (below) begin
                        if (!cooling_next) begin
                            // The first cool update only starts the count.
                            cooling_next = 1'b1;
                            count_next   = '0;
                        end else if (count_next >= ticks) begin
                            estop_next   = 1'b0;
                            cooling_next = 1'b0;
                            count_next   = '0;
                        end
                    end else begin
                        cooling_next = 1'b0;
                        count_next   = '0;
                    end
                end
                if (warn_cond && !warning_reg) begin
                    warning_next = 1'b1;
                end else if (warning_reg && below) begin
                    warning_next = 1'b0;
                end
                last_max_next = best_val;
                last_hot_next = best_idx;
            end
            tew_pkg::CMD_TICK: begin
                if (cooling_reg && (count_reg != '1)) begin
                    count_next = count_reg + 1'b1;
                end
            end
            tew_pkg::CMD_RESET: begin
                if (!estop_reg) begin
                    ok_next = 1'b1;
                end else if (last_max_reg < levels.warn) begin
                    estop_next   = 1'b0;
                    cooling_next = 1'b0;
                    count_next   = '0;
                    ok_next      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            estop_reg    <= 1'b0;
            warning_reg  <= 1'b0;
            cooling_reg  <= 1'b0;
            count_reg    <= '0;
            last_max_reg <= '0;
            last_hot_reg <= IDX_W'(CHANNELS);
            ok_reg       <= 1'b0;
        end else if (fire) begin
            estop_reg    <= estop_next;
            warning_reg  <= warning_next;
            cooling_reg  <= cooling_next;
            count_reg    <= count_next;
            last_max_reg <= last_max_next;
            last_hot_reg <= last_hot_next;
            ok_reg       <= ok_next;
        end
    end

    assign status.estop    = estop_reg;
    assign status.warning  = warning_reg;
    assign status.cooling  = cooling_reg;
    assign status.reset_ok = ok_reg;
    assign status.max_temp = last_max_reg;
    assign hot_idx         = last_hot_reg;

endmodule

// ===== rtl/thermal_estop_watchdog.sv =====
// Top level of the thermal e-stop watchdog: ports, configuration, pipeline control.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Content
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: command, group; tdata: lanes
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: latches, maximum, hot channel
// cfg       in         cfg_we (always taken)          register index and write data
//
// Every transaction produces exactly one result transaction. The result is registered
// first in the search stage and then in the latch stage before it is offered.
// One transaction is accepted per cycle unless a stalled result holds a full search stage;
// the limit is the loop through the lane write muxes and the maximum tree, which must see
// the previous transaction's writes. The output register doubles as the latch state,
// so a stalled result holds the pipeline stage behind it; a new transaction is still
// taken while that stage is empty. aresetn is synchronous and active low; it clears
// all temperatures, latches and counters and restores the register defaults.

module thermal_estop_watchdog #(
    parameter int CHANNELS    = 16,
    parameter int GROUP_LANES = 8,
    parameter int COUNT_WIDTH = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, lowest bit up: lane_count[3:0], temp_0 .. temp_7 (16 bits each), 4 zero bits.
    input  logic [135:0] s_axis_tdata,
    // tuser, lowest bit up: command[1:0], group[2].
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, lowest bit up: estop, warning, max_temp[14:0], hot_channel[4:0], cooling,
    // reset_ok.
    output logic [23:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata
);

    localparam int IDX_W = $clog2(CHANNELS + 1);

    // ---------------------------------------------------------------------
    // Configuration registers. The cooldown count is kept at COUNT_WIDTH bits.
    // ---------------------------------------------------------------------
    tew_pkg::levels_t        levels_reg;
    logic [COUNT_WIDTH-1:0]  ticks_reg;
    logic [55:0]             cfg_wide;
    logic [31:0]             ticks_rst;

    assign cfg_wide  = {32'd0, cfg_wdata};
    assign ticks_rst = tew_pkg::COOLDOWN_RST;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg.estop <= tew_pkg::ESTOP_LEVEL_RST;
            levels_reg.warn  <= tew_pkg::WARN_LEVEL_RST;
            levels_reg.clear <= tew_pkg::CLEAR_LEVEL_RST;
            ticks_reg        <= ticks_rst[COUNT_WIDTH-1:0];
        end else if (cfg_we) begin
            unique case (cfg_addr)
                tew_pkg::REG_ESTOP_LEVEL:    levels_reg.estop <= cfg_wdata[14:0];
                tew_pkg::REG_WARN_LEVEL:     levels_reg.warn  <= cfg_wdata[14:0];
                tew_pkg::REG_CLEAR_LEVEL:    levels_reg.clear <= cfg_wdata[14:0];
                tew_pkg::REG_COOLDOWN_TICKS: ticks_reg        <= cfg_wide[COUNT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control. Stage one holds the search result, stage two is the
    // latch state that also forms the output transaction.
    // ---------------------------------------------------------------------
    logic       p1_valid_reg, p1_valid_next;
    logic [1:0] p1_cmd_reg;
    logic       m_valid_reg, m_valid_next;
    logic       out_ready, p1_adv, s_fire, upd_en;

    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign p1_adv        = p1_valid_reg && out_ready;
    assign s_axis_tready = !p1_valid_reg || out_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign upd_en        = s_fire && (s_axis_tuser[1:0] == tew_pkg::CMD_UPDATE);

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_fire) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_cmd_reg <= s_axis_tuser[1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Channel lanes: each one stores a temperature and offers it to the search.
    // ---------------------------------------------------------------------
    tew_pkg::cand_t cands [CHANNELS];

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        localparam int LANE = ch % GROUP_LANES;
        tew_lane #(
            .CH          (ch),
            .GROUP_LANES (GROUP_LANES)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .upd_en     (upd_en),
            .group_sel  (s_axis_tuser[2]),
            .lane_count (s_axis_tdata[3:0]),
            .wdata      (s_axis_tdata[4 + 16*LANE +: 16]),
            .cand       (cands[ch])
        );
    end

    // ---------------------------------------------------------------------
    // Merge of the lanes into the hottest channel.
    // ---------------------------------------------------------------------
    logic [tew_pkg::LEVEL_W-1:0] best_val;
    logic [IDX_W-1:0]            best_idx;

    tew_max #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_max (
        .aclk         (aclk),
        .load         (s_fire),
        .cands        (cands),
        .best_val_reg (best_val),
        .best_idx_reg (best_idx)
    );

    // ---------------------------------------------------------------------
    // Latches and cooldown counter; their registers drive the result.
    // ---------------------------------------------------------------------
    tew_pkg::status_t status;
    logic [IDX_W-1:0] hot_idx;
    logic [31:0]      hot_wide;

    tew_latch #(
        .CHANNELS    (CHANNELS),
        .IDX_W       (IDX_W),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_latch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (p1_adv),
        .cmd      (p1_cmd_reg),
        .best_val (best_val),
        .best_idx (best_idx),
        .levels   (levels_reg),
        .ticks    (ticks_reg),
        .status   (status),
        .hot_idx  (hot_idx)
    );

    assign hot_wide      = 32'(hot_idx);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {status.reset_ok, status.cooling, hot_wide[4:0],
                            status.max_temp, status.warning, status.estop};

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // The cooldown counter only runs while the e-stop is latched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.cooling |-> status.estop)
        else $error("cooldown running without a latched e-stop");

    // An accepted manual reset always leaves the e-stop released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.reset_ok |-> !status.estop)
        else $error("manual reset accepted while e-stop still latched");

    // No hot channel exactly when the recorded maximum is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hot_idx == IDX_W'(CHANNELS)) == (status.max_temp == '0))
        else $error("hot channel and maximum disagree");

    // An accepted transaction always occupies the search stage next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> p1_valid_reg)
        else $error("accepted transaction lost before the latch stage");

endmodule
